/* src/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* src/c6502_pkg.sv */
package c6502_pkg;
   localparam int MemBytes = 65536;
   localparam int MemAw = $clog2(MemBytes);
   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0, ACT_READ = 2'd1, ACT_EXEC = 2'd2, ACT_LOAD = 2'd3
   } action_type;
   typedef struct packed {
      logic [1:0] action;
      logic [15:0] addr;
      logic [7:0] wdata;
   } req_type;
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] xreg;
      logic [7:0] yreg;
      logic [7:0] stack_ptr;
      logic [7:0] status;
      logic [15:0] prog_counter;
      logic [7:0] rdata;
      logic unknown_op;
   } rsp_type;
   localparam logic [7:0] FL_C = 8'h01;
   localparam logic [7:0] FL_Z = 8'h02;
   localparam logic [7:0] FL_I = 8'h04;
   localparam logic [7:0] FL_D = 8'h08;
   localparam logic [7:0] FL_B = 8'h10;
   localparam logic [7:0] FL_V = 8'h40;
   localparam logic [7:0] FL_N = 8'h80;

   localparam logic [7:0] OP_BRK = 8'h00;
   localparam logic [7:0] OP_BPL = 8'h10;
   localparam logic [7:0] OP_BMI = 8'h30;
   localparam logic [7:0] OP_BVC = 8'h50;
   localparam logic [7:0] OP_BVS = 8'h70;
   localparam logic [7:0] OP_BCC = 8'h90;
   localparam logic [7:0] OP_BCS = 8'hB0;
   localparam logic [7:0] OP_BNE = 8'hD0;
   localparam logic [7:0] OP_BEQ = 8'hF0;
   localparam logic [7:0] OP_CLC = 8'h18;
   localparam logic [7:0] OP_SEC = 8'h38;
   localparam logic [7:0] OP_CLI = 8'h58;
   localparam logic [7:0] OP_SEI = 8'h78;
   localparam logic [7:0] OP_CLV = 8'hB8;
   localparam logic [7:0] OP_CLD = 8'hD8;
   localparam logic [7:0] OP_SED = 8'hF8;
   localparam logic [7:0] OP_JMP_ABS = 8'h4C;
   localparam logic [7:0] OP_JMP_IND = 8'h6C;
   localparam logic [7:0] OP_JSR = 8'h20;
   localparam logic [7:0] OP_RTS = 8'h60;
   localparam logic [7:0] OP_RTI = 8'h40;
   localparam logic [7:0] OP_CPX_IMM = 8'hE0;
   localparam logic [7:0] OP_CPX_ZP = 8'hE4;
   localparam logic [7:0] OP_CPX_ABS = 8'hEC;
   localparam logic [7:0] OP_CPY_IMM = 8'hC0;
   localparam logic [7:0] OP_CPY_ZP = 8'hC4;
   localparam logic [7:0] OP_CPY_ABS = 8'hCC;
   localparam logic [7:0] OP_NOP = 8'hEA;
   localparam logic [7:0] OP_INX = 8'hE8;
   localparam logic [7:0] OP_INY = 8'hC8;
   localparam logic [7:0] OP_DEX = 8'hCA;
   localparam logic [7:0] OP_DEY = 8'h88;
   localparam logic [7:0] OP_TAX = 8'hAA;
   localparam logic [7:0] OP_TAY = 8'hA8;
   localparam logic [7:0] OP_TXA = 8'h8A;
   localparam logic [7:0] OP_TYA = 8'h98;
   localparam logic [7:0] OP_TXS = 8'h9A;
   localparam logic [7:0] OP_TSX = 8'hBA;
   localparam logic [7:0] OP_PHA = 8'h48;
   localparam logic [7:0] OP_PHP = 8'h08;
   localparam logic [7:0] OP_PLA = 8'h68;
   localparam logic [7:0] OP_PLP = 8'h28;
   localparam logic [7:0] OP_INC_ZP = 8'hE6;
   localparam logic [7:0] OP_INC_ZPX = 8'hF6;
   localparam logic [7:0] OP_INC_ABS = 8'hEE;
   localparam logic [7:0] OP_INC_ABSX = 8'hFE;
endpackage

/* src/c6502_if.sv */
interface c6502_req_if;
   logic valid;
   logic ready;
   c6502_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface c6502_rsp_if;
   logic valid;
   logic ready;
   c6502_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/cpu6502_subset_executor_core.sv */
// 6502-subset core with a private byte memory.
// req: one transfer carries action, addr and wdata. action write stores a
// byte, read returns one in rdata, load sets pc, execute runs the
// instruction at pc. rsp: one transfer per request with the full register
// state after it.
// Memory bytes sit in one single-port synchronous memory with registered read
// data; an instruction runs as a sequencer with one memory access per step,
// each access an issue state followed by a use or write-back state.
// Write and load go straight to the response step, read passes through S_RD,
// execute of implied ops decodes only, and BRK decodes, does three pushes and
// two vector reads, then responds. RTI pulls three stack bytes.
// One item is in flight at a time; the next request is taken in the cycle
// after the response register loads.
// Reset (synchronous) clears a, x, y, flags and pc, sets sp to 0xff and
// empties the response register; memory keeps its contents.
// When the receiver stalls the response stays held; a following item runs
// up to its response step and waits there, and no further request is taken.
module cpu6502_subset_executor_core (
   input logic clock,
   input logic reset,
   c6502_req_if.sink req_ch,
   c6502_rsp_if.source rsp_ch
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_ISSUE = 7'b0000010, S_DEC = 7'b0000100,
      S_RESP = 7'b0001000, S_HOLD = 7'b0010000, S_FIN = 7'b0100000,
      S_RD = 7'b1000000
   } state_type;

   logic [7:0] mem [c6502_pkg::MemBytes];
   logic [7:0] mrd_ff;
   logic m_we;
   logic [15:0] m_addr;
   logic [7:0] m_wd;

   state_type st_ff, st_in;
   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0] op_ff, op_in, t_ff, t_in;
   logic [15:0] ea_ff, ea_in;
   logic [3:0] k_ff, k_in;
   logic unk_ff, unk_in;
   logic [7:0] rdat_ff, rdat_in;
   logic ov_ff, ov_in;
   c6502_pkg::rsp_type od_ff, od_in;

   always_ff @(posedge clock) begin
      if (m_we) mem[m_addr[c6502_pkg::MemAw-1:0]] <= m_wd;
      mrd_ff <= mem[m_addr[c6502_pkg::MemAw-1:0]];
   end

   function automatic logic [7:0] nz(input logic [7:0] f, input logic [7:0] v);
      logic [7:0] r;
      r = f & ~(c6502_pkg::FL_N | c6502_pkg::FL_Z);
      if (v == 8'd0) r = r | c6502_pkg::FL_Z;
      r = r | (v & c6502_pkg::FL_N);
      return r;
   endfunction

   assign req_ch.ready = (st_ff == S_IDLE);
   assign rsp_ch.valid = ov_ff;
   assign rsp_ch.data = od_ff;

   // one memory access per sequencer step: S_ISSUE drives it, S_HOLD uses read data, S_FIN follows a write
   always_comb begin
      logic [7:0] m;
      logic [8:0] d;
      logic tk;
      st_in = st_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff;
      p_in = p_ff; pc_in = pc_ff; op_in = op_ff; t_in = t_ff; ea_in = ea_ff;
      k_in = k_ff; unk_in = unk_ff; rdat_in = rdat_ff; ov_in = ov_ff; od_in = od_ff;
      m_we = 1'b0; m_addr = 16'd0; m_wd = 8'd0;
      m = mrd_ff; d = 9'd0; tk = 1'b0;
      if (ov_ff && rsp_ch.ready) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               unk_in = 1'b0; rdat_in = 8'd0;
               k_in = 4'd0;
               unique case (c6502_pkg::action_type'(req_ch.data.action))
                  c6502_pkg::ACT_WRITE: begin
                     m_we = 1'b1; m_addr = req_ch.data.addr;
                     m_wd = req_ch.data.wdata; st_in = S_RESP;
                  end
                  c6502_pkg::ACT_READ: begin
                     m_addr = req_ch.data.addr; st_in = S_RD;
                  end
                  c6502_pkg::ACT_LOAD: begin
                     pc_in = req_ch.data.addr; st_in = S_RESP;
                  end
                  c6502_pkg::ACT_EXEC: begin
                     m_addr = pc_ff; st_in = S_DEC;
                  end
                  default: st_in = S_RESP;
               endcase
            end
         end
         S_RD: begin
            rdat_in = m; st_in = S_RESP;
         end
         S_DEC: begin
            op_in = m; pc_in = pc_ff + 16'd1; st_in = S_RESP;
            priority case (m)
               c6502_pkg::OP_CLC: p_in = p_ff & ~c6502_pkg::FL_C;
               c6502_pkg::OP_SEC: p_in = p_ff | c6502_pkg::FL_C;
               c6502_pkg::OP_CLI: p_in = p_ff & ~c6502_pkg::FL_I;
               c6502_pkg::OP_SEI: p_in = p_ff | c6502_pkg::FL_I;
               c6502_pkg::OP_CLV: p_in = p_ff & ~c6502_pkg::FL_V;
               c6502_pkg::OP_CLD: p_in = p_ff & ~c6502_pkg::FL_D;
               c6502_pkg::OP_SED: p_in = p_ff | c6502_pkg::FL_D;
               c6502_pkg::OP_NOP: ;
               c6502_pkg::OP_INX: begin
                  x_in = x_ff + 8'd1; p_in = nz(p_ff, x_ff + 8'd1);
               end
               c6502_pkg::OP_INY: begin
                  y_in = y_ff + 8'd1; p_in = nz(p_ff, y_ff + 8'd1);
               end
               c6502_pkg::OP_DEX: begin
                  x_in = x_ff - 8'd1; p_in = nz(p_ff, x_ff - 8'd1);
               end
               c6502_pkg::OP_DEY: begin
                  y_in = y_ff - 8'd1; p_in = nz(p_ff, y_ff - 8'd1);
               end
               c6502_pkg::OP_TAX: begin x_in = a_ff; p_in = nz(p_ff, a_ff); end
               c6502_pkg::OP_TAY: begin y_in = a_ff; p_in = nz(p_ff, a_ff); end
               c6502_pkg::OP_TXA: begin a_in = x_ff; p_in = nz(p_ff, x_ff); end
               c6502_pkg::OP_TYA: begin a_in = y_ff; p_in = nz(p_ff, y_ff); end
               c6502_pkg::OP_TXS: sp_in = x_ff;
               c6502_pkg::OP_TSX: begin x_in = sp_ff; p_in = nz(p_ff, sp_ff); end
               c6502_pkg::OP_BRK, c6502_pkg::OP_BPL, c6502_pkg::OP_BMI,
               c6502_pkg::OP_BVC, c6502_pkg::OP_BVS, c6502_pkg::OP_BCC,
               c6502_pkg::OP_BCS, c6502_pkg::OP_BNE, c6502_pkg::OP_BEQ,
               c6502_pkg::OP_JMP_ABS, c6502_pkg::OP_JMP_IND, c6502_pkg::OP_JSR,
               c6502_pkg::OP_RTS, c6502_pkg::OP_RTI, c6502_pkg::OP_CPX_IMM,
               c6502_pkg::OP_CPX_ZP, c6502_pkg::OP_CPX_ABS, c6502_pkg::OP_CPY_IMM,
               c6502_pkg::OP_CPY_ZP, c6502_pkg::OP_CPY_ABS, c6502_pkg::OP_PHA,
               c6502_pkg::OP_PHP, c6502_pkg::OP_PLA, c6502_pkg::OP_PLP,
               c6502_pkg::OP_INC_ZP, c6502_pkg::OP_INC_ZPX, c6502_pkg::OP_INC_ABS,
               c6502_pkg::OP_INC_ABSX: begin
                  pc_in = pc_ff; st_in = S_ISSUE;
               end
               default: unk_in = 1'b1;
            endcase
         end
         S_ISSUE: begin
            st_in = S_HOLD;
            priority case (op_ff)
               c6502_pkg::OP_BRK: begin
                  if (k_ff == 4'd0) begin
                     m_we = 1'b1; m_addr = {8'h01, sp_ff};
                     m_wd = pc_ff[15:8] + {7'd0, pc_ff[7:0] > 8'hFD};
                  end else if (k_ff == 4'd1) begin
                     m_we = 1'b1; m_addr = {8'h01, sp_ff}; m_wd = pc_ff[7:0] + 8'd2;
                  end else if (k_ff == 4'd2) begin
                     m_we = 1'b1; m_addr = {8'h01, sp_ff};
                     m_wd = p_ff | c6502_pkg::FL_B;
                  end else if (k_ff == 4'd3) m_addr = 16'hFFFE;
                  else m_addr = 16'hFFFF;
               end
               c6502_pkg::OP_JSR: begin
                  if (k_ff == 4'd0) m_addr = pc_ff + 16'd1;
                  else if (k_ff == 4'd1) m_addr = pc_ff + 16'd2;
                  else if (k_ff == 4'd2) begin
                     m_we = 1'b1; m_addr = {8'h01, sp_ff}; m_wd = pc_ff[15:8];
                  end else begin
                     m_we = 1'b1; m_addr = {8'h01, sp_ff}; m_wd = pc_ff[7:0];
                  end
               end
               c6502_pkg::OP_RTS, c6502_pkg::OP_RTI, c6502_pkg::OP_PLA,
               c6502_pkg::OP_PLP: m_addr = {8'h01, sp_ff + 8'd1};
               c6502_pkg::OP_PHA: begin
                  m_we = 1'b1; m_addr = {8'h01, sp_ff}; m_wd = a_ff;
               end
               c6502_pkg::OP_PHP: begin
                  m_we = 1'b1; m_addr = {8'h01, sp_ff}; m_wd = p_ff;
               end
               default: begin
                  // operand fetch chain: ea_ff holds the pointer being built
                  if (k_ff == 4'd0) m_addr = pc_ff + 16'd1;
                  else if (k_ff == 4'd1) m_addr = pc_ff + 16'd2;
                  else if (k_ff == 4'd2) m_addr = ea_ff;
                  else if (k_ff == 4'd3) m_addr = ea_ff + 16'd1;
                  else begin m_we = 1'b1; m_addr = ea_ff; m_wd = t_ff; end
               end
            endcase
            if (m_we) st_in = S_FIN;
         end
         S_FIN: begin
            // after a write step
            st_in = S_ISSUE; k_in = k_ff + 4'd1;
            priority case (op_ff)
               c6502_pkg::OP_BRK: sp_in = sp_ff - 8'd1;
               c6502_pkg::OP_JSR: begin
                  sp_in = sp_ff - 8'd1;
                  if (k_ff == 4'd3) begin pc_in = ea_ff; st_in = S_RESP; end
               end
               c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
                  sp_in = sp_ff - 8'd1; pc_in = pc_ff + 16'd1; st_in = S_RESP;
               end
               default: begin
                  p_in = nz(p_ff, t_ff);
                  pc_in = pc_ff + ((op_ff == c6502_pkg::OP_INC_ZP ||
                                    op_ff == c6502_pkg::OP_INC_ZPX) ? 16'd2 : 16'd3);
                  st_in = S_RESP;
               end
            endcase
         end
         S_HOLD: begin
            // read data from the issue step is valid here
            st_in = S_ISSUE; k_in = k_ff + 4'd1;
            priority case (op_ff)
               c6502_pkg::OP_BRK: begin
                  if (k_ff == 4'd3) ea_in[7:0] = m;
                  else begin
                     pc_in = {m, ea_ff[7:0]}; p_in = p_ff | c6502_pkg::FL_I;
                     st_in = S_RESP;
                  end
               end
               c6502_pkg::OP_JSR: begin
                  if (k_ff == 4'd0) ea_in[7:0] = m;
                  else begin ea_in[15:8] = m; pc_in = pc_ff + 16'd2; end
               end
               c6502_pkg::OP_RTS: begin
                  sp_in = sp_ff + 8'd1;
                  if (k_ff == 4'd0) ea_in[7:0] = m;
                  else begin pc_in = {m, ea_ff[7:0]} + 16'd1; st_in = S_RESP; end
               end
               c6502_pkg::OP_RTI: begin
                  sp_in = sp_ff + 8'd1;
                  if (k_ff == 4'd0) p_in = m & ~c6502_pkg::FL_B;
                  else if (k_ff == 4'd1) ea_in[7:0] = m;
                  else begin pc_in = {m, ea_ff[7:0]}; st_in = S_RESP; end
               end
               c6502_pkg::OP_PLA: begin
                  sp_in = sp_ff + 8'd1; a_in = m; p_in = nz(p_ff, m);
                  pc_in = pc_ff + 16'd1; st_in = S_RESP;
               end
               c6502_pkg::OP_PLP: begin
                  sp_in = sp_ff + 8'd1; p_in = m; pc_in = pc_ff + 16'd1; st_in = S_RESP;
               end
               c6502_pkg::OP_BPL, c6502_pkg::OP_BMI, c6502_pkg::OP_BVC,
               c6502_pkg::OP_BVS, c6502_pkg::OP_BCC, c6502_pkg::OP_BCS,
               c6502_pkg::OP_BNE, c6502_pkg::OP_BEQ: begin
                  unique case (op_ff[7:6])
                     2'd0: tk = p_ff[7];
                     2'd1: tk = p_ff[6];
                     2'd2: tk = p_ff[0];
                     default: tk = p_ff[1];
                  endcase
                  pc_in = pc_ff + 16'd2;
                  if (tk == op_ff[5]) pc_in = pc_ff + 16'd2 + {{8{m[7]}}, m};
                  st_in = S_RESP;
               end
               c6502_pkg::OP_JMP_ABS: begin
                  if (k_ff == 4'd0) ea_in[7:0] = m;
                  else begin pc_in = {m, ea_ff[7:0]}; st_in = S_RESP; end
               end
               c6502_pkg::OP_JMP_IND: begin
                  if (k_ff == 4'd0) ea_in[7:0] = m;
                  else if (k_ff == 4'd1) begin ea_in[15:8] = m; k_in = 4'd2; end
                  else if (k_ff == 4'd2) t_in = m;
                  else begin pc_in = {m, t_ff}; st_in = S_RESP; end
               end
               default: begin
                  // compares and inc
                  if (op_ff == c6502_pkg::OP_CPX_IMM || op_ff == c6502_pkg::OP_CPY_IMM) begin
                     tk = 1'b1; t_in = m;
                  end else if (k_ff == 4'd0) begin
                     ea_in = {8'd0, m};
                     if (op_ff == c6502_pkg::OP_INC_ZPX) ea_in = {8'd0, m + x_ff};
                     if (op_ff == c6502_pkg::OP_CPX_ZP || op_ff == c6502_pkg::OP_CPY_ZP ||
                         op_ff == c6502_pkg::OP_INC_ZP || op_ff == c6502_pkg::OP_INC_ZPX)
                        k_in = 4'd2;
                  end else if (k_ff == 4'd1) begin
                     ea_in = {m, ea_ff[7:0]};
                     if (op_ff == c6502_pkg::OP_INC_ABSX)
                        ea_in = {m, ea_ff[7:0]} + {8'd0, x_ff};
                  end else begin
                     if (op_ff == c6502_pkg::OP_INC_ZP || op_ff == c6502_pkg::OP_INC_ZPX ||
                         op_ff == c6502_pkg::OP_INC_ABS || op_ff == c6502_pkg::OP_INC_ABSX)
                     begin
                        t_in = m + 8'd1; k_in = 4'd4;
                     end else begin
                        tk = 1'b1; t_in = m;
                     end
                  end
                  if (tk) begin
                     d = (op_ff[5] ? {1'b0, x_ff} : {1'b0, y_ff}) - {1'b0, t_in};
                     p_in = nz(p_ff, d[7:0]);
                     p_in[0] = ~d[8];
                     pc_in = pc_ff + ((op_ff[3:2] == 2'b11) ? 16'd3 : 16'd2);
                     st_in = S_RESP;
                  end
               end
            endcase
         end
         S_RESP: begin
            if (!ov_ff || rsp_ch.ready) begin
               ov_in = 1'b1;
               od_in.acc = a_ff; od_in.xreg = x_ff; od_in.yreg = y_ff;
               od_in.stack_ptr = sp_ff; od_in.status = p_ff;
               od_in.prog_counter = pc_ff; od_in.rdata = rdat_ff;
               od_in.unknown_op = unk_ff;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0;
         sp_ff <= 8'hFF; p_ff <= 8'd0; pc_ff <= 16'd0; ov_ff <= 1'b0;
         k_ff <= 4'd0; unk_ff <= 1'b0; rdat_ff <= 8'd0;
      end else begin
         st_ff <= st_in; a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         sp_ff <= sp_in; p_ff <= p_in; pc_ff <= pc_in; ov_ff <= ov_in;
         k_ff <= k_in; unk_ff <= unk_in; rdat_ff <= rdat_in;
      end
      op_ff <= op_in; t_ff <= t_in; ea_ff <= ea_in; od_ff <= od_in;
   end
endmodule

/* src/c6502_checker.sv */
`include "assert_macros.svh"
module c6502_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input c6502_pkg::rsp_type rsp_data
);
   `ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_NEXT(one_inflight, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPL(rdata_only_read, clock, reset, rsp_valid && rsp_data.unknown_op, rsp_data.rdata == 8'd0)
endmodule

bind cpu6502_subset_executor_core c6502_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data)
);

/* test/tb_cpu6502_subset_executor_core.sv */
`timescale 1ns / 1ps

module tb_cpu6502_subset_executor_core;
   localparam logic [15:0] VEC_LO = 16'hFFFE;
   localparam logic [15:0] VEC_HI = 16'hFFFF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   localparam logic [7:0] SUPPORTED_OPS [46] = '{
      c6502_pkg::OP_BRK, c6502_pkg::OP_BPL, c6502_pkg::OP_BMI, c6502_pkg::OP_BVC,
      c6502_pkg::OP_BVS, c6502_pkg::OP_BCC, c6502_pkg::OP_BCS, c6502_pkg::OP_BNE,
      c6502_pkg::OP_BEQ, c6502_pkg::OP_CLC, c6502_pkg::OP_SEC, c6502_pkg::OP_CLI,
      c6502_pkg::OP_SEI, c6502_pkg::OP_CLV, c6502_pkg::OP_CLD, c6502_pkg::OP_SED,
      c6502_pkg::OP_JMP_ABS, c6502_pkg::OP_JMP_IND, c6502_pkg::OP_JSR,
      c6502_pkg::OP_RTS, c6502_pkg::OP_RTI, c6502_pkg::OP_CPX_IMM,
      c6502_pkg::OP_CPX_ZP, c6502_pkg::OP_CPX_ABS, c6502_pkg::OP_CPY_IMM,
      c6502_pkg::OP_CPY_ZP, c6502_pkg::OP_CPY_ABS, c6502_pkg::OP_NOP,
      c6502_pkg::OP_INX, c6502_pkg::OP_INY, c6502_pkg::OP_DEX, c6502_pkg::OP_DEY,
      c6502_pkg::OP_TAX, c6502_pkg::OP_TAY, c6502_pkg::OP_TXA, c6502_pkg::OP_TYA,
      c6502_pkg::OP_TXS, c6502_pkg::OP_TSX, c6502_pkg::OP_PHA, c6502_pkg::OP_PHP,
      c6502_pkg::OP_PLA, c6502_pkg::OP_PLP, c6502_pkg::OP_INC_ZP,
      c6502_pkg::OP_INC_ZPX, c6502_pkg::OP_INC_ABS, c6502_pkg::OP_INC_ABSX
   };

   class cpu_state;
      bit [7:0] mem [65536];
      bit written [65536];
      bit [15:0] written_q [$];
      bit [7:0] a, x, y, s, p;
      bit [15:0] pc;

      function new();
         s = 8'hFF;
      endfunction

      function bit [7:0] rd(bit [15:0] ad);
         return mem[ad];
      endfunction

      function void wr(bit [15:0] ad, bit [7:0] v);
         mem[ad] = v;
         if (!written[ad]) begin
            written[ad] = 1;
            written_q.push_back(ad);
         end
      endfunction

      function bit [15:0] rd16(bit [15:0] ad);
         bit [15:0] nx;
         nx = ad + 16'd1;
         return {mem[nx], mem[ad]};
      endfunction

      function void push(bit [7:0] v);
         wr({8'h01, s}, v);
         s = s - 8'd1;
      endfunction

      function bit [7:0] pop();
         s = s + 8'd1;
         return mem[{8'h01, s}];
      endfunction

      function void setnz(bit [7:0] v);
         p = (p & ~(c6502_pkg::FL_N | c6502_pkg::FL_Z)) | (v & c6502_pkg::FL_N) |
             ((v == 8'd0) ? c6502_pkg::FL_Z : 8'd0);
      endfunction

      function void cmp(bit [7:0] r, bit [7:0] m);
         p = (r >= m) ? (p | c6502_pkg::FL_C) : (p & ~c6502_pkg::FL_C);
         setnz(r - m);
      endfunction

      function bit run_op();
         bit [7:0] op, m, lo, hi;
         bit [15:0] nxt, ea, ret;
         bit taken;
         op = rd(pc);
         nxt = pc + 16'd1;
         case (op)
            c6502_pkg::OP_BRK: begin
               ret = pc + 16'd2;
               push(ret[15:8]);
               push(ret[7:0]);
               push(p | c6502_pkg::FL_B);
               p = p | c6502_pkg::FL_I;
               pc = {mem[VEC_HI], mem[VEC_LO]};
               return 0;
            end
            c6502_pkg::OP_BPL, c6502_pkg::OP_BMI, c6502_pkg::OP_BVC, c6502_pkg::OP_BVS,
            c6502_pkg::OP_BCC, c6502_pkg::OP_BCS, c6502_pkg::OP_BNE,
            c6502_pkg::OP_BEQ: begin
               case (op[7:6])
                  2'd0: m = p & c6502_pkg::FL_N;
                  2'd1: m = p & c6502_pkg::FL_V;
                  2'd2: m = p & c6502_pkg::FL_C;
                  default: m = p & c6502_pkg::FL_Z;
               endcase
               taken = ((m != 8'd0) == op[5]);
               ea = pc + 16'd2;
               if (taken) begin
                  m = rd(pc + 16'd1);
                  ea = ea + {{8{m[7]}}, m};
               end
               pc = ea;
               return 0;
            end
            c6502_pkg::OP_CLC: p = p & ~c6502_pkg::FL_C;
            c6502_pkg::OP_SEC: p = p | c6502_pkg::FL_C;
            c6502_pkg::OP_CLI: p = p & ~c6502_pkg::FL_I;
            c6502_pkg::OP_SEI: p = p | c6502_pkg::FL_I;
            c6502_pkg::OP_CLV: p = p & ~c6502_pkg::FL_V;
            c6502_pkg::OP_CLD: p = p & ~c6502_pkg::FL_D;
            c6502_pkg::OP_SED: p = p | c6502_pkg::FL_D;
            c6502_pkg::OP_JMP_ABS: begin
               pc = rd16(pc + 16'd1);
               return 0;
            end
            c6502_pkg::OP_JMP_IND: begin
               pc = rd16(rd16(pc + 16'd1));
               return 0;
            end
            c6502_pkg::OP_JSR: begin
               ea = rd16(pc + 16'd1);
               ret = pc + 16'd2;
               push(ret[15:8]);
               push(ret[7:0]);
               pc = ea;
               return 0;
            end
            c6502_pkg::OP_RTS: begin
               lo = pop();
               hi = pop();
               pc = {hi, lo} + 16'd1;
               return 0;
            end
            c6502_pkg::OP_RTI: begin
               p = pop() & ~c6502_pkg::FL_B;
               lo = pop();
               hi = pop();
               pc = {hi, lo};
               return 0;
            end
            c6502_pkg::OP_CPX_IMM: begin cmp(x, rd(pc + 16'd1)); nxt = pc + 16'd2; end
            c6502_pkg::OP_CPX_ZP: begin
               cmp(x, rd({8'h00, rd(pc + 16'd1)})); nxt = pc + 16'd2;
            end
            c6502_pkg::OP_CPX_ABS: begin cmp(x, rd(rd16(pc + 16'd1))); nxt = pc + 16'd3; end
            c6502_pkg::OP_CPY_IMM: begin cmp(y, rd(pc + 16'd1)); nxt = pc + 16'd2; end
            c6502_pkg::OP_CPY_ZP: begin
               cmp(y, rd({8'h00, rd(pc + 16'd1)})); nxt = pc + 16'd2;
            end
            c6502_pkg::OP_CPY_ABS: begin cmp(y, rd(rd16(pc + 16'd1))); nxt = pc + 16'd3; end
            c6502_pkg::OP_NOP: ;
            c6502_pkg::OP_INX: begin x = x + 8'd1; setnz(x); end
            c6502_pkg::OP_INY: begin y = y + 8'd1; setnz(y); end
            c6502_pkg::OP_DEX: begin x = x - 8'd1; setnz(x); end
            c6502_pkg::OP_DEY: begin y = y - 8'd1; setnz(y); end
            c6502_pkg::OP_TAX: begin x = a; setnz(x); end
            c6502_pkg::OP_TAY: begin y = a; setnz(y); end
            c6502_pkg::OP_TXA: begin a = x; setnz(a); end
            c6502_pkg::OP_TYA: begin a = y; setnz(a); end
            c6502_pkg::OP_TXS: s = x;
            c6502_pkg::OP_TSX: begin x = s; setnz(x); end
            c6502_pkg::OP_PHA: push(a);
            c6502_pkg::OP_PHP: push(p);
            c6502_pkg::OP_PLA: begin a = pop(); setnz(a); end
            c6502_pkg::OP_PLP: p = pop();
            c6502_pkg::OP_INC_ZP, c6502_pkg::OP_INC_ZPX, c6502_pkg::OP_INC_ABS,
            c6502_pkg::OP_INC_ABSX: begin
               case (op)
                  c6502_pkg::OP_INC_ZP: begin
                     ea = {8'h00, rd(pc + 16'd1)}; nxt = pc + 16'd2;
                  end
                  c6502_pkg::OP_INC_ZPX: begin
                     m = rd(pc + 16'd1) + x;
                     ea = {8'h00, m};
                     nxt = pc + 16'd2;
                  end
                  c6502_pkg::OP_INC_ABS: begin ea = rd16(pc + 16'd1); nxt = pc + 16'd3; end
                  default: begin ea = rd16(pc + 16'd1) + {8'h00, x}; nxt = pc + 16'd3; end
               endcase
               m = rd(ea) + 8'd1;
               wr(ea, m);
               setnz(m);
            end
            default: begin
               pc = pc + 16'd1;
               return 1;
            end
         endcase
         pc = nxt;
         return 0;
      endfunction

      function c6502_pkg::rsp_type step(c6502_pkg::req_type r);
         c6502_pkg::rsp_type o;
         o = '0;
         case (c6502_pkg::action_type'(r.action))
            c6502_pkg::ACT_WRITE: wr(r.addr, r.wdata);
            c6502_pkg::ACT_READ: o.rdata = rd(r.addr);
            c6502_pkg::ACT_EXEC: o.unknown_op = run_op();
            default: pc = r.addr;
         endcase
         o.acc = a;
         o.xreg = x;
         o.yreg = y;
         o.stack_ptr = s;
         o.status = p;
         o.prog_counter = pc;
         return o;
      endfunction
   endclass

   class cpu_scoreboard;
      cpu_state model;
      c6502_pkg::rsp_type state_q [$];
      int errors;
      int checked;

      function new();
         model = new();
      endfunction

      function void note_request(c6502_pkg::req_type r);
         state_q.push_back(model.step(r));
      endfunction

      function void field(string nm, logic [15:0] e, logic [15:0] g);
         if (e !== g) begin
            errors++;
            $display("%0t: %s mismatch expected %h actual %h", $time, nm, e, g);
         end
      endfunction

      function void check_response(c6502_pkg::rsp_type g);
         c6502_pkg::rsp_type e;
         if (state_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response expected none actual %h", $time, g);
            return;
         end
         e = state_q.pop_front();
         checked++;
         field("acc", e.acc, g.acc);
         field("xreg", e.xreg, g.xreg);
         field("yreg", e.yreg, g.yreg);
         field("stack_ptr", e.stack_ptr, g.stack_ptr);
         field("status", e.status, g.status);
         field("prog_counter", e.prog_counter, g.prog_counter);
         field("rdata", e.rdata, g.rdata);
         field("unknown_op", e.unknown_op, g.unknown_op);
      endfunction
   endclass

   logic clock;
   logic reset;
   c6502_req_if req_if();
   c6502_rsp_if rsp_if();

   cpu6502_subset_executor_core uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if.sink),
      .rsp_ch(rsp_if.source)
   );

   cpu_scoreboard sb;
   cpu_state plan;
   int src_pct;
   int snk_pct;
   bit hold_req;
   bit hold_done;
   int hold_left;
   int sent;
   int execs;
   int idle_cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response side with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         hold_done = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
         if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_pct);
         if (hold_left > 0) hold_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_cpu6502_subset_executor_core: FAIL");
         $finish;
      end
   end

   task automatic send(c6502_pkg::action_type act, logic [15:0] ad, logic [7:0] wd);
      c6502_pkg::req_type r;
      r.action = act;
      r.addr = ad;
      r.wdata = wd;
      void'(plan.step(r));
      if ($urandom_range(99) < src_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_pct);
      end
      req_if.valid <= 1'b1;
      req_if.data <= r;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(r);
      sent++;
   endtask

   task automatic make_known(logic [15:0] ad);
      if (!plan.written[ad]) send(c6502_pkg::ACT_WRITE, ad, 8'($urandom));
   endtask

   // lays down the instruction at pc and every byte it will read, then runs it
   task automatic run_instr(logic [7:0] op);
      logic [15:0] pc0, ptr;
      logic [7:0] zp;
      pc0 = plan.pc;
      send(c6502_pkg::ACT_WRITE, pc0, op);
      send(c6502_pkg::ACT_WRITE, pc0 + 16'd1, 8'($urandom));
      send(c6502_pkg::ACT_WRITE, pc0 + 16'd2, 8'($urandom));
      ptr = plan.rd16(pc0 + 16'd1);
      zp = plan.rd(pc0 + 16'd1);
      case (op)
         c6502_pkg::OP_BRK: begin make_known(VEC_LO); make_known(VEC_HI); end
         c6502_pkg::OP_JMP_IND: begin make_known(ptr); make_known(ptr + 16'd1); end
         c6502_pkg::OP_RTS: begin
            make_known({8'h01, plan.s + 8'd1});
            make_known({8'h01, plan.s + 8'd2});
         end
         c6502_pkg::OP_RTI: begin
            make_known({8'h01, plan.s + 8'd1});
            make_known({8'h01, plan.s + 8'd2});
            make_known({8'h01, plan.s + 8'd3});
         end
         c6502_pkg::OP_PLA, c6502_pkg::OP_PLP: make_known({8'h01, plan.s + 8'd1});
         c6502_pkg::OP_CPX_ZP, c6502_pkg::OP_CPY_ZP, c6502_pkg::OP_INC_ZP:
            make_known({8'h00, zp});
         c6502_pkg::OP_INC_ZPX: make_known({8'h00, zp + plan.x});
         c6502_pkg::OP_CPX_ABS, c6502_pkg::OP_CPY_ABS, c6502_pkg::OP_INC_ABS:
            make_known(ptr);
         c6502_pkg::OP_INC_ABSX: make_known(ptr + {8'h00, plan.x});
         default: ;
      endcase
      send(c6502_pkg::ACT_EXEC, 16'h0000, 8'($urandom));
      execs++;
   endtask

   task automatic random_items(int upto);
      int k;
      logic [7:0] op;
      while (sent < upto) begin
         k = $urandom_range(99);
         if (k < 65) begin
            if ($urandom_range(9) == 0) op = 8'($urandom);
            else op = SUPPORTED_OPS[$urandom_range(45)];
            run_instr(op);
         end else if (k < 73) begin
            send(c6502_pkg::ACT_LOAD, 16'($urandom), 8'($urandom));
         end else if (k < 86) begin
            send(c6502_pkg::ACT_WRITE, 16'($urandom), 8'($urandom));
         end else begin
            send(c6502_pkg::ACT_READ,
               plan.written_q[$urandom_range(plan.written_q.size() - 1)], 8'($urandom));
         end
      end
   endtask

   initial begin
      sb = new();
      plan = new();
      src_pct = 0;
      snk_pct = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: address extremes, pc wrap, vectors, unknown opcode
      send(c6502_pkg::ACT_WRITE, 16'h0000, 8'hFF);
      send(c6502_pkg::ACT_WRITE, 16'hFFFF, 8'h00);
      send(c6502_pkg::ACT_READ, 16'h0000, 8'hFF);
      send(c6502_pkg::ACT_READ, 16'hFFFF, 8'h00);
      send(c6502_pkg::ACT_LOAD, 16'hFFFF, 8'h00);
      run_instr(c6502_pkg::OP_BRK);
      run_instr(c6502_pkg::OP_RTI);
      send(c6502_pkg::ACT_LOAD, 16'hFFFE, 8'h00);
      run_instr(c6502_pkg::OP_JMP_IND);
      run_instr(8'h02);
      run_instr(c6502_pkg::OP_TSX);

      random_items(220);
      src_pct = 56;
      hold_req = 1;
      random_items(430);
      src_pct = 0;
      snk_pct = 56;
      random_items(640);
      src_pct = 22;
      snk_pct = 22;
      random_items(850);
      req_if.valid <= 1'b0;

      while (sb.state_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d transfers, %0d instructions executed, %0d responses checked",
         sent, execs, sb.checked);
      $display("idle and stall phases plus one long response hold-off applied");
      if (sb.errors == 0 && sb.state_q.size() == 0) begin
         $display("tb_cpu6502_subset_executor_core: PASS");
      end else begin
         $display("tb_cpu6502_subset_executor_core: FAIL");
      end
      $finish;
   end
endmodule
